/* rtl/core/region_harmonic_mean_color_core_assert.svh */
// Assertion macros used by the checker module of this block.
`ifndef REGION_HARMONIC_MEAN_COLOR_CORE_ASSERT_SVH
`define REGION_HARMONIC_MEAN_COLOR_CORE_ASSERT_SVH

// Checked at every rising edge of clk, ignored while rst_n is low.
`define RHM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define RHM_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/rhm_pkg.sv */
package rhm_pkg;

	// Longest region that is still counted, and the fraction bits of a reciprocal.
	localparam int MAX_PIXELS      = 65536;
	localparam int RECIP_FRAC_BITS = 24;

	localparam int NCHAN   = 3;
	localparam int CHAN_W  = 2;
	localparam int PIX_W   = 8;
	localparam int MEAN_W  = 8;

	localparam int CNT_W   = $clog2(MAX_PIXELS + 1);
	localparam int SUM_W   = CNT_W + RECIP_FRAC_BITS;
	localparam int RECIP_W = RECIP_FRAC_BITS + 1;

	// Nine quotient bits: eight for the mean and one that flags an overflow.
	localparam int QUO_W   = MEAN_W + 1;
	localparam int BIT_W   = $clog2(QUO_W);
	localparam int ALU_W   = SUM_W + QUO_W;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		alu_op_t            op;
		logic [ALU_W-1:0]   a;
		logic [ALU_W-1:0]   b;
	} alu_in_t;

	typedef struct packed {
		logic [ALU_W-1:0]   value;
		logic               carry;
	} alu_out_t;

endpackage

/* rtl/core/region_harmonic_mean_color_core.sv */
// Channel   Valid          Stall          Payload
// pixel     pixel_valid    pixel_stall    channel_0, channel_1, channel_2, last_pixel
// mean      mean_valid     mean_stall     mean_0, mean_1, mean_2, clipped
//
// A pixel request that is not the last of its region is accepted and then accumulated, one
// channel at a time, through the shared adder.
// For the last pixel, each channel then has its numerator formed, and nine restoring steps of
// the same unit give the quotient; then the result is handed off.
// Reset clears the sums, the pixel counter and the sequencer at once; no pass is needed.
// A waiting mean request does not hold back new pixels until the next result is ready; the
// hand-off of that result then waits, with pixels stalled, until the output register is free.
module region_harmonic_mean_color_core (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         pixel_valid,
	output logic                         pixel_stall,
	input  logic [rhm_pkg::PIX_W-1:0]    channel_0,
	input  logic [rhm_pkg::PIX_W-1:0]    channel_1,
	input  logic [rhm_pkg::PIX_W-1:0]    channel_2,
	input  logic                         last_pixel,

	output logic                         mean_valid,
	input  logic                         mean_stall,
	output logic [rhm_pkg::MEAN_W-1:0]   mean_0,
	output logic [rhm_pkg::MEAN_W-1:0]   mean_1,
	output logic [rhm_pkg::MEAN_W-1:0]   mean_2,
	output logic                         clipped
);

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_ACC  = 5'b00010,
		ST_LOAD = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t                              state_q;
	logic [rhm_pkg::CHAN_W-1:0]          chan_q;
	logic [rhm_pkg::BIT_W-1:0]           bit_q;

	// Latched pixel request.
	logic [rhm_pkg::PIX_W-1:0]           pix_q [rhm_pkg::NCHAN];
	logic                                last_q;
	logic                                acc_en_q;

	// Region state.
	logic [rhm_pkg::SUM_W-1:0]           sums_q [rhm_pkg::NCHAN];
	logic [rhm_pkg::CNT_W-1:0]           count_q;

	// Division working registers.
	logic [rhm_pkg::ALU_W-1:0]           rem_q;
	logic [rhm_pkg::ALU_W-1:0]           div_q;
	logic [rhm_pkg::QUO_W-2:0]           quo_q;
	logic [rhm_pkg::MEAN_W-1:0]          work_q [rhm_pkg::NCHAN];
	logic                                clip_q;

	// Output register.
	logic                                mean_valid_q;
	logic [rhm_pkg::MEAN_W-1:0]          mean_q [rhm_pkg::NCHAN];
	logic                                clipped_q;

	rhm_pkg::alu_in_t                    alu_in;
	rhm_pkg::alu_out_t                   alu_out;

	logic [rhm_pkg::RECIP_W-1:0]         recip_tab [2**rhm_pkg::PIX_W];
	logic [rhm_pkg::QUO_W-1:0]           quo_full;
	logic                                quo_bit;
	logic                                sat;
	logic                                load_out;
	logic                                accept;

	// Reciprocal table floor(2^F / v), with zero for a zero channel so that it adds nothing.
	localparam logic [63:0] RecipOne = 64'd1 << rhm_pkg::RECIP_FRAC_BITS;
	for (genvar i = 0; i < 2**rhm_pkg::PIX_W; i++) begin : g_recip
		localparam logic [rhm_pkg::RECIP_W-1:0] Entry = (i == 0) ?
			rhm_pkg::RECIP_W'(0) :
			rhm_pkg::RECIP_W'(RecipOne / ((i == 0) ? 1 : i));
		assign recip_tab[i] = Entry;
	end

	rhm_alu u_alu (
		.ctl (alu_in),
		.res (alu_out)
	);

	// The adder accumulates reciprocals, forms each numerator and runs the division steps.
	always_comb begin
		alu_in.op = rhm_pkg::ALU_ADD;
		alu_in.a  = '0;
		alu_in.b  = '0;
		unique case (state_q)
			ST_ACC: begin
				alu_in.a = rhm_pkg::ALU_W'(sums_q[chan_q]);
				alu_in.b = rhm_pkg::ALU_W'(recip_tab[pix_q[chan_q]]);
			end
			ST_LOAD: begin
				// Numerator 2 * (count << F) + sum gives the half-up rounding.
				alu_in.a = rhm_pkg::ALU_W'({count_q, {(rhm_pkg::RECIP_FRAC_BITS + 1){1'b0}}});
				alu_in.b = rhm_pkg::ALU_W'(sums_q[chan_q]);
			end
			ST_DIV: begin
				alu_in.op = rhm_pkg::ALU_SUB;
				alu_in.a  = rem_q;
				alu_in.b  = div_q;
			end
			default: begin
				alu_in.op = rhm_pkg::ALU_ADD;
			end
		endcase
	end

	// A step that does not borrow sets its quotient bit. A zero sum never borrows, so the
	// overflow bit comes up and the mean saturates as it should.
	assign quo_bit  = ~alu_out.carry;
	assign quo_full = {quo_q, quo_bit};
	assign sat      = quo_full[rhm_pkg::QUO_W-1];

	assign accept   = (state_q == ST_IDLE) && pixel_valid;
	assign load_out = (state_q == ST_DONE) && (!mean_valid_q || !mean_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			chan_q   <= '0;
			bit_q    <= '0;
			count_q  <= '0;
			acc_en_q <= 1'b0;
			last_q   <= 1'b0;
			clip_q   <= 1'b0;
			for (int c = 0; c < rhm_pkg::NCHAN; c++) begin
				sums_q[c] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// Once the region is full, further pixels are neither counted nor summed.
						acc_en_q <= (count_q < rhm_pkg::CNT_W'(rhm_pkg::MAX_PIXELS));
						if (count_q < rhm_pkg::CNT_W'(rhm_pkg::MAX_PIXELS)) begin
							count_q <= count_q + rhm_pkg::CNT_W'(1);
						end
						last_q  <= last_pixel;
						chan_q  <= '0;
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (acc_en_q) begin
						sums_q[chan_q] <= alu_out.value[rhm_pkg::SUM_W-1:0];
					end
					if (chan_q == rhm_pkg::CHAN_W'(rhm_pkg::NCHAN - 1)) begin
						chan_q  <= '0;
						clip_q  <= 1'b0;
						state_q <= last_q ? ST_LOAD : ST_IDLE;
					end else begin
						chan_q <= chan_q + rhm_pkg::CHAN_W'(1);
					end
				end
				ST_LOAD: begin
					bit_q   <= rhm_pkg::BIT_W'(rhm_pkg::QUO_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					bit_q <= bit_q - rhm_pkg::BIT_W'(1);
					if (bit_q == '0) begin
						clip_q <= clip_q | sat;
						if (chan_q == rhm_pkg::CHAN_W'(rhm_pkg::NCHAN - 1)) begin
							state_q <= ST_DONE;
						end else begin
							chan_q  <= chan_q + rhm_pkg::CHAN_W'(1);
							state_q <= ST_LOAD;
						end
					end
				end
				ST_DONE: begin
					if (load_out) begin
						count_q <= '0;
						for (int c = 0; c < rhm_pkg::NCHAN; c++) begin
							sums_q[c] <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Pixel latch and division datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q[0] <= channel_0;
			pix_q[1] <= channel_1;
			pix_q[2] <= channel_2;
		end
		if (state_q == ST_LOAD) begin
			rem_q <= alu_out.value;
			// Divisor is twice the sum, aligned to the top quotient bit.
			div_q <= {sums_q[chan_q], 1'b0, {(rhm_pkg::QUO_W - 1){1'b0}}};
			quo_q <= '0;
		end
		if (state_q == ST_DIV) begin
			if (quo_bit) begin
				rem_q <= alu_out.value;
			end
			div_q <= div_q >> 1;
			quo_q <= quo_full[rhm_pkg::QUO_W-2:0];
			if (bit_q == '0) begin
				work_q[chan_q] <= sat ? {rhm_pkg::MEAN_W{1'b1}} : quo_full[rhm_pkg::MEAN_W-1:0];
			end
		end
		if (load_out) begin
			for (int c = 0; c < rhm_pkg::NCHAN; c++) begin
				mean_q[c] <= work_q[c];
			end
			clipped_q <= clip_q;
		end
	end

	// The output register is refilled in the cycle its request is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_valid_q <= 1'b0;
		end else if (load_out) begin
			mean_valid_q <= 1'b1;
		end else if (!mean_stall) begin
			mean_valid_q <= 1'b0;
		end
	end

	assign pixel_stall = (state_q != ST_IDLE);
	assign mean_valid  = mean_valid_q;
	assign mean_0      = mean_q[0];
	assign mean_1      = mean_q[1];
	assign mean_2      = mean_q[2];
	assign clipped     = clipped_q;

endmodule

/* rtl/core/rhm_alu.sv */
// Shared adder and subtractor. For a subtraction the carry is the borrow.
module rhm_alu (
	input  rhm_pkg::alu_in_t  ctl,
	output rhm_pkg::alu_out_t res
);

	logic [rhm_pkg::ALU_W:0] wide;

	always_comb begin
		case (ctl.op)
			rhm_pkg::ALU_SUB: wide = {1'b0, ctl.a} - {1'b0, ctl.b};
			default:          wide = {1'b0, ctl.a} + {1'b0, ctl.b};
		endcase
	end

	assign res.value = wide[rhm_pkg::ALU_W-1:0];
	assign res.carry = wide[rhm_pkg::ALU_W];

endmodule

/* rtl/core/rhm_checker.sv */
`include "region_harmonic_mean_color_core_assert.svh"

module rhm_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pixel_valid,
	input  logic                         pixel_stall,
	input  logic [rhm_pkg::PIX_W-1:0]    channel_0,
	input  logic [rhm_pkg::PIX_W-1:0]    channel_1,
	input  logic [rhm_pkg::PIX_W-1:0]    channel_2,
	input  logic                         last_pixel,
	input  logic                         mean_valid,
	input  logic                         mean_stall,
	input  logic [rhm_pkg::MEAN_W-1:0]   mean_0,
	input  logic [rhm_pkg::MEAN_W-1:0]   mean_1,
	input  logic [rhm_pkg::MEAN_W-1:0]   mean_2,
	input  logic                         clipped
);

	logic [rhm_pkg::PIX_W*3:0] pixel_bits;
	assign pixel_bits = {channel_0, channel_1, channel_2, last_pixel};

	// A held mean request keeps its payload.
	`RHM_ASSERT(a_mean_hold, clk, arst_n, mean_valid && mean_stall |=> mean_valid && $stable(mean_0) && $stable(mean_1) && $stable(mean_2) && $stable(clipped), "mean request changed while stalled")

	// A clipped result has at least one channel pinned at full scale.
	`RHM_ASSERT(a_clip_full, clk, arst_n, mean_valid && clipped |-> (mean_0 == '1) || (mean_1 == '1) || (mean_2 == '1), "clipped set without a saturated channel")

	// Accepting a pixel takes the sequencer out of idle, so the one after an accept is always stalled.
	`RHM_ASSERT(a_pixel_busy, clk, arst_n, pixel_valid && !pixel_stall && !$isunknown(pixel_bits) |=> pixel_stall, "pixel accepted on consecutive cycles")

	// An edge that sees reset held is followed by one with no result offered.
	`RHM_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> !mean_valid, "mean request during reset")

endmodule

bind region_harmonic_mean_color_core rhm_checker u_rhm_checker (.*);
